// ----- rtl/fnps_pkg.sv -----
// Shared types and constants for the filtered nearest point search block.
// No dependencies; imported by every module of the block.
package fnps_pkg;

  localparam int COORD_W    = 24;
  localparam int TAG_W      = 16;
  localparam int MAG_W      = COORD_W + 1;
  localparam int SQ_W       = 2 * MAG_W - 1;
  localparam int DIST_W     = 50;
  localparam int SLOT_OUT_W = 12;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [2:0] {
    REG_QUERY_X      = 3'd0,
    REG_QUERY_Y      = 3'd1,
    REG_QUERY_Z      = 3'd2,
    REG_WANT_TYPE    = 3'd3,
    REG_WANT_SUBTYPE = 3'd4,
    REG_EITHER_MATCH = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] query_z;
    logic [TAG_W-1:0]          want_type;
    logic [TAG_W-1:0]          want_subtype;
    logic                      either_match;
  } cfg_t;

  // One classified request as it travels from front to back.
  typedef struct packed {
    logic                  qual;
    logic                  last;
    logic [SLOT_OUT_W-1:0] slot;
    logic [DIST_W-1:0]     sq_dist;
  } q_entry_t;

endpackage

// ----- rtl/filtered_nearest_point_search.sv -----
// Top level of the filtered nearest point search block.
// Depends on fnps_pkg, fnps_regs, fnps_front, fnps_queue and fnps_back.
//
//   channel   direction  handshake            payload
//   input     in         in_valid_i/in_stall_o   point_x/y/z, point_type, point_subtype,
//                                                  slot_used, last_point
//   result    out        out_valid_o/out_stall_i best_slot, best_dist_sq, found
//   config    in         APB psel/penable       query_x/y/z, want_type, want_subtype,
//                                                  either_match at 4*index
//
// One request per cycle sustained while the front is not stalled on credit. A
// request passes three front stages (difference, square, sum) and then the
// 8-entry queue to the back end, which registers the result in its output
// register when the last point of the scan is popped.
// The front stalls on credit: queue occupancy plus requests in its stages
// reaching the queue depth. Only a last point waits for the output register.
// Reset clears config, slot numbering, running best and all valid flags.
module filtered_nearest_point_search
  import fnps_pkg::*;
#(
  parameter int MAX_POINTS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]     pwdata,
  output logic [APB_DATA_W-1:0]     prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic [TAG_W-1:0]          point_type_i,
  input  logic [TAG_W-1:0]          point_subtype_i,
  input  logic                      slot_used_i,
  input  logic                      last_point_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [SLOT_OUT_W-1:0]     best_slot_o,
  output logic [DIST_W-1:0]         best_dist_sq_o,
  output logic                      found_o
);

  cfg_t              cfg;
  logic              push;
  q_entry_t          push_data;
  logic              pop;
  logic              q_empty;
  q_entry_t          q_head;
  logic [QCNT_W-1:0] q_count;

  fnps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // classify and measure each point
  fnps_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .point_type_i    (point_type_i),
    .point_subtype_i (point_subtype_i),
    .slot_used_i     (slot_used_i),
    .last_point_i    (last_point_i),
    .q_count_i       (q_count),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  fnps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head),
    .count_o     (q_count)
  );

  // running best and result register
  fnps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_i         (q_head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .best_slot_o    (best_slot_o),
    .best_dist_sq_o (best_dist_sq_o),
    .found_o        (found_o)
  );

endmodule

// ----- rtl/fnps_regs.sv -----
// APB register file holding the query point and the tag filters.
// Depends on fnps_pkg.
module fnps_regs
  import fnps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_QUERY_X:      cfg_d.query_x      = pwdata[COORD_W-1:0];
        REG_QUERY_Y:      cfg_d.query_y      = pwdata[COORD_W-1:0];
        REG_QUERY_Z:      cfg_d.query_z      = pwdata[COORD_W-1:0];
        REG_WANT_TYPE:    cfg_d.want_type    = pwdata[TAG_W-1:0];
        REG_WANT_SUBTYPE: cfg_d.want_subtype = pwdata[TAG_W-1:0];
        REG_EITHER_MATCH: cfg_d.either_match = pwdata[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_QUERY_X:      prdata = APB_DATA_W'(unsigned'(cfg_q.query_x));
      REG_QUERY_Y:      prdata = APB_DATA_W'(unsigned'(cfg_q.query_y));
      REG_QUERY_Z:      prdata = APB_DATA_W'(unsigned'(cfg_q.query_z));
      REG_WANT_TYPE:    prdata = APB_DATA_W'(cfg_q.want_type);
      REG_WANT_SUBTYPE: prdata = APB_DATA_W'(cfg_q.want_subtype);
      REG_EITHER_MATCH: prdata = APB_DATA_W'(cfg_q.either_match);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/fnps_front.sv -----
// Front end: accepts points, applies the tag filter, numbers the slots and
// works out the squared distance over three stages. Depends on fnps_pkg.
module fnps_front
  import fnps_pkg::*;
#(
  parameter int MAX_POINTS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic [TAG_W-1:0]          point_type_i,
  input  logic [TAG_W-1:0]          point_subtype_i,
  input  logic                      slot_used_i,
  input  logic                      last_point_i,
  input  logic [QCNT_W-1:0]         q_count_i,
  output logic                      push_o,
  output q_entry_t                  push_data_o
);

  localparam int SLOT_W = $clog2(MAX_POINTS);

  logic                   accept;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [1:0]             inflight;
  logic [QCNT_W:0]        credit_used;

  // stage A: magnitudes of the differences
  logic                   a_valid_q;
  logic                   a_qual_q, a_last_q;
  logic [SLOT_OUT_W-1:0]  a_slot_q;
  logic [MAG_W-1:0]       a_mag_q [3];
  logic [MAG_W-1:0]       a_mag_d [3];
  logic signed [MAG_W-1:0] diff [3];
  logic                   tmatch, smatch, qual;

  // stage B: squares
  logic                   b_valid_q;
  logic                   b_qual_q, b_last_q;
  logic [SLOT_OUT_W-1:0]  b_slot_q;
  logic [SQ_W-1:0]        b_sq_q [3];
  logic [2*MAG_W-1:0]     prod [3];

  // stage C: sum
  logic                   c_valid_q;
  q_entry_t               c_entry_q, c_entry_d;

  assign accept = in_valid_i & ~in_stall_o;

  // Credit check: queue occupancy plus everything still in the stages.
  assign inflight    = 2'(a_valid_q) + 2'(b_valid_q) + 2'(c_valid_q);
  assign credit_used = (QCNT_W+1)'(q_count_i) + (QCNT_W+1)'(inflight);
  assign in_stall_o  = credit_used >= (QCNT_W+1)'(QUEUE_DEPTH);

  always_comb begin
    tmatch = (cfg_i.want_type == '0) || (cfg_i.want_type == point_type_i);
    smatch = (cfg_i.want_subtype == '0) || (cfg_i.want_subtype == point_subtype_i);
    qual   = slot_used_i & (cfg_i.either_match ? (tmatch | smatch) : (tmatch & smatch));

    diff[0] = MAG_W'(point_x_i) - MAG_W'(cfg_i.query_x);
    diff[1] = MAG_W'(point_y_i) - MAG_W'(cfg_i.query_y);
    diff[2] = MAG_W'(point_z_i) - MAG_W'(cfg_i.query_z);
    for (int i = 0; i < 3; i++) begin
      a_mag_d[i] = diff[i][MAG_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
    end

    for (int i = 0; i < 3; i++) begin
      prod[i] = {{MAG_W{1'b0}}, a_mag_q[i]} * {{MAG_W{1'b0}}, a_mag_q[i]};
    end

    c_entry_d.qual    = b_qual_q;
    c_entry_d.last    = b_last_q;
    c_entry_d.slot    = b_slot_q;
    c_entry_d.sq_dist = DIST_W'(b_sq_q[0]) + DIST_W'(b_sq_q[1]) + DIST_W'(b_sq_q[2]);
  end

  // Slot numbering wraps at the table size and restarts after a last point.
  always_comb begin
    slot_d = slot_q;
    if (accept) begin
      if (last_point_i || (slot_q == SLOT_W'(MAX_POINTS - 1))) begin
        slot_d = '0;
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      a_valid_q <= accept;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_qual_q  <= qual;
    a_last_q  <= last_point_i;
    a_slot_q  <= SLOT_OUT_W'(slot_q);
    b_qual_q  <= a_qual_q;
    b_last_q  <= a_last_q;
    b_slot_q  <= a_slot_q;
    for (int i = 0; i < 3; i++) begin
      a_mag_q[i] <= a_mag_d[i];
      b_sq_q[i]  <= SQ_W'(prod[i]);
    end
    c_entry_q <= c_entry_d;
  end

  assign push_o      = c_valid_q;
  assign push_data_o = c_entry_q;

endmodule

// ----- rtl/fnps_queue.sv -----
// Short request queue between front and back ends.
// Depends on fnps_pkg.
module fnps_queue
  import fnps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  q_entry_t          push_data_i,
  input  logic              pop_i,
  output logic              empty_o,
  output q_entry_t          head_o,
  output logic [QCNT_W-1:0] count_o
);

  q_entry_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/fnps_back.sv -----
// Back end: keeps the running best over a scan and registers the result.
// Depends on fnps_pkg.
module fnps_back
  import fnps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  q_entry_t              head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SLOT_OUT_W-1:0] best_slot_o,
  output logic [DIST_W-1:0]     best_dist_sq_o,
  output logic                  found_o
);

  logic [DIST_W-1:0]     best_q, best_d, best_n;
  logic [SLOT_OUT_W-1:0] idx_q, idx_d, idx_n;
  logic                  have_q, have_d, have_n;
  logic                  take;

  logic                  out_valid_q, out_valid_d;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [DIST_W-1:0]     out_dist_q;
  logic                  out_found_q;
  logic                  emit;

  // A last point needs a free output register; others always go through.
  assign pop_o = ~empty_i & (~head_i.last | ~out_valid_q | ~out_stall_i);
  assign emit  = pop_o & head_i.last;

  always_comb begin
    // first qualifying point always wins; later ones only when strictly nearer
    take   = head_i.qual & (~have_q | (head_i.sq_dist < best_q));
    best_n = take ? head_i.sq_dist : best_q;
    idx_n  = take ? head_i.slot : idx_q;
    have_n = have_q | take;

    best_d = best_q;
    idx_d  = idx_q;
    have_d = have_q;
    if (pop_o) begin
      if (head_i.last) begin
        best_d = DIST_MAX;
        idx_d  = '0;
        have_d = 1'b0;
      end else begin
        best_d = best_n;
        idx_d  = idx_n;
        have_d = have_n;
      end
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= DIST_MAX;
      idx_q       <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      best_q      <= best_d;
      idx_q       <= idx_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  // While nothing qualified the running best still holds its cleared values.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_slot_q  <= idx_n;
      out_dist_q  <= best_n;
      out_found_q <= have_n;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign best_slot_o    = out_slot_q;
  assign best_dist_sq_o = out_dist_q;
  assign found_o        = out_found_q;

endmodule

// ----- rtl/fnps_checker.sv -----
// Port-level checks for the filtered nearest point search block, bound to
// the top level. Depends on fnps_pkg.
module fnps_checker
  import fnps_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  pready,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [SLOT_OUT_W-1:0] best_slot_o,
  input logic [DIST_W-1:0]     best_dist_sq_o,
  input logic                  found_o
);

  localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(3) << 48;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(best_slot_o)
      && $stable(best_dist_sq_o) && $stable(found_o))
    else $error("result changed while stalled");

  // empty scan reports slot zero and the maximum distance
  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> best_slot_o == '0 && best_dist_sq_o == DIST_MAX)
    else $error("empty scan result malformed");

  // three squared magnitudes, each below 2^24, cannot exceed 3 * 2^48
  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> best_dist_sq_o <= DIST_BOUND)
    else $error("distance out of range");

  a_no_result_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o && pready)
    else $error("result valid straight out of reset");

endmodule

bind filtered_nearest_point_search fnps_checker u_fnps_checker (.*);
